// ===== src/sab_pkg.sv =====
// Shared types and constants for the selective acknowledgement aggregator.
// Used by sab_ctrl, sab_datapath and the top level; depends on nothing.
package sab_pkg;

  localparam int WIN_W      = 6;
  localparam int AGG_W      = 16;
  localparam int DRAW_W     = 16;
  localparam int CNT_W      = 17;
  localparam int WEFF_W     = 7;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_USER_W  = 2;

  localparam logic [WIN_W-1:0]     WINDOW_RESET = WIN_W'(32);
  localparam logic [CNT_W-1:0]     ELAPSED_MAX  = {CNT_W{1'b1}};
  localparam logic                 ACT_ACK      = 1'b0;
  localparam logic                 ACT_TICK     = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AGG      = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DECIDE,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic tick;
    logic latch;
    logic update;
    logic commit;
    logic div_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic send;
    logic agg_zero;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== src/selective_ack_bitmap_aggregator.sv =====
// Selective acknowledgement bitmap aggregator: an ack request in the ack phase passes through
// the update and decision steps and yields one result in the output register. No new request
// is taken until the controller is back in idle, after the decision step or, when a send with
// nonzero aggregation runs the 16-step serial remainder that picks the next jittered interval,
// after that divide; tick requests and requests outside the ack phase give no result. The
// result register holds one result; a further ack request waits in the decision step until
// that result is taken. Depends on sab_pkg, sab_ctrl and sab_datapath.
module selective_ack_bitmap_aggregator #(
  parameter int ID_BITS     = 32,
  parameter int BITMAP_BITS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // message_id, random_draw
  input  logic [((ID_BITS+sab_pkg::DRAW_W+7)/8)*8-1:0] in_tdata,
  // action, ack_phase
  input  logic [sab_pkg::IN_USER_W-1:0]               in_tuser,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // send_now, highest_acked, ack_bitmap
  output logic [((1+ID_BITS+BITMAP_BITS+7)/8)*8-1:0]   out_tdata,
  input  logic                                        cfg_we,
  input  logic [sab_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [sab_pkg::CFG_DATA_W-1:0]              cfg_wdata
);

  localparam int OUT_DATA_W = ((1 + ID_BITS + BITMAP_BITS + 7) / 8) * 8;

  sab_pkg::ctrl_cmd_t  cmd;
  sab_pkg::dp_status_t status;
  logic                send_now;
  logic [ID_BITS-1:0]  highest_acked;
  logic [BITMAP_BITS-1:0] ack_bitmap;

  sab_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_action    (in_tuser[0]),
    .in_ack_phase (in_tuser[1]),
    .status       (status),
    .cmd          (cmd)
  );

  sab_datapath #(
    .ID_BITS     (ID_BITS),
    .BITMAP_BITS (BITMAP_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_message_id     (in_tdata[ID_BITS-1:0]),
    .in_random_draw    (in_tdata[ID_BITS +: sab_pkg::DRAW_W]),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_tready        (out_tready),
    .out_valid         (out_tvalid),
    .out_send_now      (send_now),
    .out_highest_acked (highest_acked),
    .out_ack_bitmap    (ack_bitmap)
  );

  assign out_tdata = OUT_DATA_W'({ack_bitmap, highest_acked, send_now});

endmodule

// ===== src/sab_ctrl.sv =====
// Controller state machine for the selective acknowledgement aggregator.
// Depends on sab_pkg; drives datapath commands from datapath status.
module sab_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_action,
  input  logic                in_ack_phase,
  input  sab_pkg::dp_status_t status,
  output sab_pkg::ctrl_cmd_t  cmd
);

  sab_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sab_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sab_pkg::ST_IDLE: begin
        if (accept && in_action == sab_pkg::ACT_ACK && in_ack_phase) begin
          state_nxt = sab_pkg::ST_UPDATE;
        end
      end
      sab_pkg::ST_UPDATE: begin
        state_nxt = sab_pkg::ST_DECIDE;
      end
      sab_pkg::ST_DECIDE: begin
        if (!status.out_busy) begin
          state_nxt = (status.send && !status.agg_zero) ? sab_pkg::ST_DIV : sab_pkg::ST_IDLE;
        end
      end
      sab_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = sab_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sab_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      sab_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = accept;
        cmd.tick  = accept && in_action == sab_pkg::ACT_TICK;
      end
      sab_pkg::ST_UPDATE: cmd.update   = 1'b1;
      sab_pkg::ST_DECIDE: cmd.commit   = !status.out_busy;
      sab_pkg::ST_DIV:    cmd.div_step = 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sab_pkg::ST_UPDATE |-> $past(accept) && $past(in_ack_phase))
    else $error("update entered without an accepted ack request");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && status.send && !status.agg_zero |=> state_r == sab_pkg::ST_DIV)
    else $error("send with aggregation did not start the interval divide");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sab_pkg::ST_DECIDE && status.out_busy |=> state_r == sab_pkg::ST_DECIDE)
    else $error("decision left while result register still occupied");

endmodule

// ===== src/sab_datapath.sv =====
// Datapath: configuration, window bitmap, tick counter, jitter divider and result register.
// Depends on sab_pkg; sequenced by sab_ctrl through ctrl_cmd_t.
module sab_datapath #(
  parameter int ID_BITS     = 32,
  parameter int BITMAP_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sab_pkg::ctrl_cmd_t                 cmd,
  output sab_pkg::dp_status_t                status,
  input  logic [ID_BITS-1:0]                 in_message_id,
  input  logic [sab_pkg::DRAW_W-1:0]         in_random_draw,
  input  logic                               cfg_we,
  input  logic [sab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sab_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               out_tready,
  output logic                               out_valid,
  output logic                               out_send_now,
  output logic [ID_BITS-1:0]                 out_highest_acked,
  output logic [BITMAP_BITS-1:0]             out_ack_bitmap
);

  localparam int WW = sab_pkg::WEFF_W;

  logic [sab_pkg::WIN_W-1:0]     window_r;
  logic [sab_pkg::AGG_W-1:0]     agg_r;
  logic [ID_BITS-1:0]            id_r, highest_r, highest_nxt, gap, off, weff_id;
  logic [sab_pkg::DRAW_W-1:0]    draw_r, dvd_r;
  logic [BITMAP_BITS-1:0]        bits_r, bits_nxt, win_full, one_w, one_gap, one_off;
  logic                          have_id_r;
  logic [sab_pkg::CNT_W-1:0]     elapsed_r, jitter_r, divisor, trial, rem_r, rem_nxt;
  logic [sab_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [WW-1:0]                 weff;
  logic                          send_c, agg_zero;
  logic                          out_valid_r, out_send_r;
  logic [ID_BITS-1:0]            out_high_r;
  logic [BITMAP_BITS-1:0]        out_mask_r;

  assign weff = ({1'b0, window_r} > WW'(BITMAP_BITS)) ? WW'(BITMAP_BITS) : {1'b0, window_r};
  assign weff_id = ID_BITS'(weff);
  assign gap     = id_r - highest_r;
  assign off     = highest_r - id_r;
  assign one_w   = BITMAP_BITS'(1) << (weff - WW'(1));
  assign one_gap = BITMAP_BITS'(1) << (gap[WW-1:0] - WW'(1));
  assign one_off = BITMAP_BITS'(1) << (off[WW-1:0] - WW'(1));

  always_comb begin
    highest_nxt = highest_r;
    bits_nxt    = bits_r;
    if (!have_id_r) begin
      highest_nxt = id_r;
      bits_nxt    = '0;
    end else if (id_r > highest_r) begin
      highest_nxt = id_r;
      if (gap >= weff_id) begin
        bits_nxt = (gap == weff_id && weff != '0) ? one_w : '0;
      end else begin
        bits_nxt = (bits_r << gap[WW-1:0]) | one_gap;
      end
    end else if (off != '0 && off <= weff_id) begin
      bits_nxt = bits_r | one_off;
    end
  end

  assign win_full = ~({BITMAP_BITS{1'b1}} << weff);
  assign agg_zero = agg_r == '0;
  assign send_c   = ((bits_r & win_full) == win_full) || agg_zero || (elapsed_r >= jitter_r);

  assign divisor = {1'b0, agg_r} + sab_pkg::CNT_W'(1);
  assign trial   = {rem_r[sab_pkg::CNT_W-2:0], dvd_r[sab_pkg::DRAW_W-1]};
  assign rem_nxt = (trial >= divisor) ? trial - divisor : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= sab_pkg::WINDOW_RESET;
      agg_r       <= '0;
      highest_r   <= '0;
      bits_r      <= '0;
      have_id_r   <= 1'b0;
      elapsed_r   <= '0;
      jitter_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sab_pkg::REG_WINDOW: window_r <= cfg_wdata[sab_pkg::WIN_W-1:0];
          sab_pkg::REG_AGG: begin
            agg_r    <= cfg_wdata[sab_pkg::AGG_W-1:0];
            jitter_r <= {1'b0, cfg_wdata[sab_pkg::AGG_W-1:0]};
          end
          default: ;
        endcase
      end
      if (cmd.tick && elapsed_r != sab_pkg::ELAPSED_MAX) begin
        elapsed_r <= elapsed_r + sab_pkg::CNT_W'(1);
      end
      if (cmd.update) begin
        highest_r <= highest_nxt;
        bits_r    <= bits_nxt;
        have_id_r <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        if (send_c) begin
          elapsed_r <= '0;
          if (agg_zero) begin
            jitter_r <= '0;
          end
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.div_step) begin
        cnt_r <= cnt_r + sab_pkg::DIV_CNT_W'(1);
        if (status.div_last) begin
          jitter_r <= {1'b0, agg_r} + rem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      id_r   <= in_message_id;
      draw_r <= in_random_draw;
    end
    if (cmd.commit) begin
      out_send_r <= send_c;
      out_high_r <= highest_r;
      out_mask_r <= bits_r;
      rem_r      <= '0;
      dvd_r      <= draw_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[sab_pkg::DRAW_W-2:0], 1'b0};
    end
  end

  assign status.send     = send_c;
  assign status.agg_zero = agg_zero;
  assign status.div_last = cnt_r == sab_pkg::DIV_CNT_W'(sab_pkg::DIV_STEPS - 1);
  assign status.out_busy = out_valid_r && !out_tready;

  assign out_valid         = out_valid_r;
  assign out_send_now      = out_send_r;
  assign out_highest_acked = out_high_r;
  assign out_ack_bitmap    = out_mask_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && send_c |=> elapsed_r == '0)
    else $error("elapsed count not cleared after a send");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> rem_r < divisor)
    else $error("divider remainder out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step && status.div_last |=> jitter_r >= {1'b0, agg_r})
    else $error("jittered interval below base aggregation interval");

endmodule
